/* src/smdd_pkg.sv */
// ----------------------------------------------------------------------------
// smdd_pkg
// Shared constants, types and the sine table of the stereo modulated delay
// doubler.
// ----------------------------------------------------------------------------
package smdd_pkg;

  localparam int DELAY_DEPTH  = 2048;
  localparam int SAMPLE_BITS  = 24;
  localparam int SINE_ENTRIES = 256;

  localparam int ADDR_BITS  = $clog2(DELAY_DEPTH);
  localparam int SINE_BITS  = $clog2(SINE_ENTRIES);
  localparam int FRAC_BITS  = 8;
  localparam int POS_BITS   = ADDR_BITS + FRAC_BITS;
  // base delay plus signed LFO offset
  localparam int DLY_BITS   = 21;
  localparam int CALC_BITS  = ((POS_BITS > DLY_BITS) ? POS_BITS : DLY_BITS) + 1;
  localparam int TDATA_BITS = ((2 * SAMPLE_BITS + 7) / 8) * 8;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [CFG_IDX_BITS-1:0] REG_BASE_DELAY   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MOD_DEPTH    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_PHASE_STEP   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_STEREO_WIDTH = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_WET_MIX      = 3'd4;

  localparam logic [18:0] BASE_DELAY_RST   = 19'd184320;
  localparam logic [15:0] MOD_DEPTH_RST    = 16'd24576;
  localparam logic [31:0] PHASE_STEP_RST   = 32'd22370;
  localparam logic [16:0] STEREO_WIDTH_RST = 17'd16384;
  localparam logic [15:0] WET_MIX_RST      = 16'd16384;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // one enable per datapath step
  typedef struct packed {
    logic load;
    logic modul;
    logic pos;
    logic rd1;
    logic rd2;
    logic interp;
    logic gain;
    logic rnd;
    logic mix;
    logic done;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

  typedef logic signed [15:0] sine_rom_t [SINE_ENTRIES];

  // Taylor series through x^13 on a Q30 quarter-wave angle
  function automatic logic signed [15:0] quarter_sine(input longint unsigned r);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint          q;
    x    = HALF_PI_Q30 * r / SINE_ENTRIES;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    term = ((term * x2) >> 30) / 6;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 20;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 42;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 72;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 110;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 156;
    sum  = sum + longint'(term);
    if (sum <= 0) begin
      return 16'sd0;
    end
    q = (sum + 16384) >>> 15;
    if (q > 32767) begin
      q = 32767;
    end
    return 16'(q);
  endfunction

  function automatic sine_rom_t build_sine();
    sine_rom_t       rom;
    longint unsigned m;
    longint unsigned quad;
    longint unsigned r;
    logic signed [15:0] v;
    for (int k = 0; k < SINE_ENTRIES; k++) begin
      m    = 4 * longint'(k);
      quad = m / SINE_ENTRIES;
      r    = m % SINE_ENTRIES;
      if (quad[0]) begin
        r = SINE_ENTRIES - r;
      end
      v      = quarter_sine(r);
      rom[k] = (quad >= 2) ? -v : v;
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine();

endpackage

/* src/smdd_ram.sv */
// ----------------------------------------------------------------------------
// smdd_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module smdd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/smdd_ctrl.sv */
// ----------------------------------------------------------------------------
// smdd_ctrl
// Sequencer: steps one item through the datapath and holds off the next
// item until the result has moved to the output register.
// ----------------------------------------------------------------------------
module smdd_ctrl
  import smdd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t st,
  output cmd_t    cmd
);

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_MOD    = 10'b0000000010,
    ST_POS    = 10'b0000000100,
    ST_RD1    = 10'b0000001000,
    ST_RD2    = 10'b0000010000,
    ST_INTERP = 10'b0000100000,
    ST_GAIN   = 10'b0001000000,
    ST_RND    = 10'b0010000000,
    ST_MIX    = 10'b0100000000,
    ST_DONE   = 10'b1000000000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.load   = in_ready && in_valid;
    cmd.modul  = (state == ST_MOD);
    cmd.pos    = (state == ST_POS);
    cmd.rd1    = (state == ST_RD1);
    cmd.rd2    = (state == ST_RD2);
    cmd.interp = (state == ST_INTERP);
    cmd.gain   = (state == ST_GAIN);
    cmd.rnd    = (state == ST_RND);
    cmd.mix    = (state == ST_MIX);
    cmd.done   = (state == ST_DONE) && st.out_free;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_MOD;
      ST_MOD:    state_next = ST_POS;
      ST_POS:    state_next = ST_RD1;
      ST_RD1:    state_next = ST_RD2;
      ST_RD2:    state_next = ST_INTERP;
      ST_INTERP: state_next = ST_GAIN;
      ST_GAIN:   state_next = ST_RND;
      ST_RND:    state_next = ST_MIX;
      ST_MIX:    state_next = ST_DONE;
      ST_DONE:   if (st.out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == ST_MOD)
    else $error("accepted item did not start the sequence");

  a_done_waits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && !st.out_free) |=> state == ST_DONE)
    else $error("result dropped while output register was full");

endmodule

/* src/smdd_dp.sv */
// ----------------------------------------------------------------------------
// smdd_dp
// Datapath: configuration registers, delay stores, LFO, fractional read,
// stereo gain, dry/wet mix and saturation.
// ----------------------------------------------------------------------------
module smdd_dp
  import smdd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  cmd_t                     cmd,
  output status_t                  st,
  input  logic [TDATA_BITS-1:0]    in_data,
  output logic [TDATA_BITS-1:0]    out_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  localparam int S = SAMPLE_BITS;

  // configuration
  logic [18:0] base_delay;
  logic [15:0] mod_depth;
  logic [31:0] phase_step;
  logic [16:0] stereo_width;
  logic [15:0] wet_mix;

  // control state
  logic [ADDR_BITS-1:0] w;
  logic                 filled;
  logic [31:0]          lfo_phase;

  // payload
  logic signed [S-1:0]     dry_l, dry_r;
  logic signed [15:0]      lfo_val;
  logic signed [32:0]      mod_prod;
  logic [POS_BITS-1:0]     pos;
  logic                    rd_ok;
  logic signed [S-1:0]     s1_l, s1_r;
  logic signed [S+9:0]     ip_l, ip_r;
  logic signed [S+18:0]    gp_l, gp_r;
  logic signed [S+2:0]     dbl_l, dbl_r;
  logic signed [S+16:0]    dp_l, dp_r;
  logic signed [S+20:0]    acc_l, acc_r;
  logic signed [S-1:0]     out_l, out_r;

  logic [ADDR_BITS-1:0]    i1, i2, raddr;
  logic [FRAC_BITS-1:0]    frac;
  logic [S-1:0]            rd_l, rd_r;
  logic signed [S-1:0]     s2_l, s2_r;
  logic signed [S:0]       diff_l, diff_r;
  logic signed [S-1:0]     dly_l, dly_r;
  logic signed [18:0]      gain_l, gain_r;
  logic signed [16:0]      dry_w, wet_w;
  logic signed [S+19:0]    wp_l, wp_r;
  logic signed [CALC_BITS-1:0] d_full, pos_full;
  logic signed [S+20:0]    rnd_l, rnd_r;
  logic signed [S-1:0]     sat_l, sat_r;

  assign i1    = pos[POS_BITS-1:FRAC_BITS];
  assign i2    = i1 + 1'b1;
  assign frac  = pos[FRAC_BITS-1:0];
  assign raddr = cmd.rd2 ? i2 : i1;

  smdd_ram #(.WIDTH(S), .DEPTH(DELAY_DEPTH)) u_ram_l (
    .clk   (clk),
    .we    (cmd.modul),
    .waddr (w),
    .wdata (dry_l),
    .raddr (raddr),
    .rdata (rd_l)
  );

  smdd_ram #(.WIDTH(S), .DEPTH(DELAY_DEPTH)) u_ram_r (
    .clk   (clk),
    .we    (cmd.modul),
    .waddr (w),
    .wdata (dry_r),
    .raddr (raddr),
    .rdata (rd_r)
  );

  // entries never written read as zero until the store has wrapped once
  assign s2_l = rd_ok ? signed'(rd_l) : '0;
  assign s2_r = rd_ok ? signed'(rd_r) : '0;

  assign d_full   = CALC_BITS'(signed'({1'b0, base_delay})) + CALC_BITS'(mod_prod >>> 15);
  assign pos_full = signed'(CALC_BITS'({w, {FRAC_BITS{1'b0}}})) - d_full;

  assign diff_l = {s2_l[S-1], s2_l} - {s1_l[S-1], s1_l};
  assign diff_r = {s2_r[S-1], s2_r} - {s1_r[S-1], s1_r};

  assign dly_l = S'((S+2)'(s1_l) + (S+2)'(ip_l >>> FRAC_BITS));
  assign dly_r = S'((S+2)'(s1_r) + (S+2)'(ip_r >>> FRAC_BITS));

  assign gain_l = 19'sh10000 - signed'({2'b00, stereo_width});
  assign gain_r = 19'sh10000 + signed'({2'b00, stereo_width});
  assign dry_w  = 17'sh08000 - signed'({1'b0, wet_mix});
  assign wet_w  = signed'({1'b0, wet_mix});

  assign wp_l = dbl_l * wet_w;
  assign wp_r = dbl_r * wet_w;

  assign rnd_l = (acc_l + (S+21)'(16384)) >>> 15;
  assign rnd_r = (acc_r + (S+21)'(16384)) >>> 15;

  // in range when all bits above the sample sign agree
  always_comb begin
    if (&rnd_l[S+20:S-1] || ~|rnd_l[S+20:S-1]) begin
      sat_l = rnd_l[S-1:0];
    end else begin
      sat_l = rnd_l[S+20] ? {1'b1, {(S-1){1'b0}}} : {1'b0, {(S-1){1'b1}}};
    end
    if (&rnd_r[S+20:S-1] || ~|rnd_r[S+20:S-1]) begin
      sat_r = rnd_r[S-1:0];
    end else begin
      sat_r = rnd_r[S+20] ? {1'b1, {(S-1){1'b0}}} : {1'b0, {(S-1){1'b1}}};
    end
  end

  assign st.out_free = !out_valid || out_ready;
  assign out_data    = TDATA_BITS'({out_r, out_l});

  always_ff @(posedge clk) begin
    if (rst) begin
      base_delay   <= BASE_DELAY_RST;
      mod_depth    <= MOD_DEPTH_RST;
      phase_step   <= PHASE_STEP_RST;
      stereo_width <= STEREO_WIDTH_RST;
      wet_mix      <= WET_MIX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BASE_DELAY:   base_delay   <= cfg_data[18:0];
        REG_MOD_DEPTH:    mod_depth    <= cfg_data[15:0];
        REG_PHASE_STEP:   phase_step   <= cfg_data[31:0];
        REG_STEREO_WIDTH: stereo_width <= cfg_data[16:0];
        REG_WET_MIX:      wet_mix      <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w         <= '0;
      filled    <= 1'b0;
      lfo_phase <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.done) begin
        w         <= w + 1'b1;
        filled    <= filled || (w == {ADDR_BITS{1'b1}});
        lfo_phase <= lfo_phase + phase_step;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dry_l   <= in_data[S-1:0];
      dry_r   <= in_data[2*S-1:S];
      lfo_val <= SINE_ROM[lfo_phase[31 -: SINE_BITS]];
    end
    if (cmd.modul) begin
      mod_prod <= lfo_val * signed'({1'b0, mod_depth});
    end
    if (cmd.pos) begin
      pos <= pos_full[POS_BITS-1:0];
    end
    if (cmd.rd1) begin
      rd_ok <= filled || (i1 <= w);
      dp_l  <= dry_l * dry_w;
      dp_r  <= dry_r * dry_w;
    end
    if (cmd.rd2) begin
      rd_ok <= filled || (i2 <= w);
      s1_l  <= s2_l;
      s1_r  <= s2_r;
    end
    if (cmd.interp) begin
      ip_l <= signed'({1'b0, frac}) * diff_l;
      ip_r <= signed'({1'b0, frac}) * diff_r;
    end
    if (cmd.gain) begin
      gp_l <= dly_l * gain_l;
      gp_r <= dly_r * gain_r;
    end
    if (cmd.rnd) begin
      dbl_l <= (S+3)'((gp_l + (S+19)'(32768)) >>> 16);
      dbl_r <= (S+3)'((gp_r + (S+19)'(32768)) >>> 16);
    end
    if (cmd.mix) begin
      acc_l <= (S+21)'(dp_l) + (S+21)'(wp_l);
      acc_r <= (S+21)'(dp_r) + (S+21)'(wp_r);
    end
    if (cmd.done) begin
      out_l <= sat_l;
      out_r <= sat_r;
    end
  end

  a_done_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.done |=> out_valid)
    else $error("finished item not presented at output");

  a_index_steps: assert property (@(posedge clk) disable iff (rst)
    cmd.done |=> w == ADDR_BITS'($past(w) + 1'b1))
    else $error("write index did not advance by one");

  a_filled_sticks: assert property (@(posedge clk) disable iff (rst)
    filled |=> filled)
    else $error("store fill flag cleared without reset");

  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.modul |-> !cmd.done)
    else $error("store write overlapped with item completion");

endmodule

/* src/stereo_modulated_delay_doubler.sv */
// ----------------------------------------------------------------------------
// stereo_modulated_delay_doubler
// Chorus-style stereo doubler: LFO-modulated fractional delay per channel,
// stereo gain spread and dry/wet mix with saturation.
// ----------------------------------------------------------------------------
// One item at a time: the next is accepted only when the sequence is idle;
//   the nine-step sequence reads both neighboring entries through each store's single read port.
// A finished item waits in the output register while the next is accepted.
// Reset (rst, synchronous): sequencer idle, registers to defaults, write index
//   and LFO phase zero; unwritten store entries read as zero, no clearing pass.
// ----------------------------------------------------------------------------
module stereo_modulated_delay_doubler
  import smdd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [TDATA_BITS-1:0]    s_axis_tdata,   // left_in, right_in
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [TDATA_BITS-1:0]    m_axis_tdata,   // left_out, right_out
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  cmd_t    cmd;
  status_t st;

  smdd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .st       (st),
    .cmd      (cmd)
  );

  smdd_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .in_data   (s_axis_tdata),
    .out_data  (m_axis_tdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the stereo modulated delay doubler. A short table of
// sample pairs and register writes covers the extremes and the special delay,
// width and mix settings. Randomized register settings with random sample
// streams follow. Each output pair is checked against a fixed pair from the
// table or a model of delay lines, sine LFO, stereo spread and wet/dry mix.
// ----------------------------------------------------------------------------
module tb_top;
  import smdd_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 7;
  localparam int DRAIN_CYCLES = 16;
  localparam int RAND_PHASES  = 7;
  localparam int PHASE_ITEMS  = 200;

  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;

  localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
  localparam longint SAMPLE_TOP    = 2 ** (SAMPLE_BITS - 1) - 1;
  localparam longint SAMPLE_BOTTOM = -SAMPLE_TOP - 1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef struct packed {
    sample_t right;
    sample_t left;
  } pair_t;

  typedef struct {
    bit                       is_write;
    logic [CFG_IDX_BITS-1:0]  reg_idx;
    logic [CFG_DATA_BITS-1:0] reg_val;
    pair_t                    dry;
    bit                       typed;
    pair_t                    want;
  } plan_row_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_STALLS, RX_TOGGLE} rx_mode_t;

  localparam sample_t SMAX     = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SMIN     = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam sample_t HALF_MAX = 24'sd4194304;
  localparam sample_t HALF_MIN = -24'sd4194304;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [TDATA_BITS-1:0]    s_axis_tdata = '0;   // left_in, right_in
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [TDATA_BITS-1:0]    m_axis_tdata;        // left_out, right_out
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  // model state
  logic signed [15:0]   sine_q15 [SINE_ENTRIES];
  sample_t              left_line [DELAY_DEPTH];
  sample_t              right_line [DELAY_DEPTH];
  logic [ADDR_BITS-1:0] head;
  logic [31:0]          lfo_phase;
  logic [18:0]          base_delay_q8;
  logic [15:0]          depth_q8;
  logic [31:0]          phase_inc;
  logic [16:0]          width_q15;
  logic [15:0]          wet_q15;

  pair_t     pending_pairs [$];
  plan_row_t plan [$];
  int        errors = 0;
  int        burst_left = 0;
  rx_mode_t  rx_mode = RX_OPEN;
  int        mode_left = 0;
  int        stall_left = 0;

  stereo_modulated_delay_doubler i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("stereo_modulated_delay_doubler test failed");
    $finish;
  end

  // full-wave sine table from a Taylor series through x^13 on a Q30 quarter-wave angle
  initial begin : sine_init
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned r;
    longint unsigned quad;
    longint unsigned divisor;
    longint          sum;
    longint          q;
    for (int k = 0; k < SINE_ENTRIES; k++) begin
      quad = (4 * k) / SINE_ENTRIES;
      r    = (4 * k) % SINE_ENTRIES;
      if (quad[0]) begin
        r = SINE_ENTRIES - r;
      end
      x    = QUARTER_TURN_Q30 * r / SINE_ENTRIES;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int j = 1; j <= 6; j++) begin
        divisor = 2 * j * (2 * j + 1);
        term    = ((term * x2) >> 30) / divisor;
        sum     = j[0] ? sum - longint'(term) : sum + longint'(term);
      end
      if (sum <= 0) begin
        q = 0;
      end else begin
        q = (sum + 16384) >>> 15;
        if (q > 32767) begin
          q = 32767;
        end
      end
      sine_q15[k] = (quad >= 2) ? -(16'(q)) : 16'(q);
    end
  end

  function automatic sample_t mix_channel(input sample_t near, input sample_t far,
                                          input logic [FRAC_BITS-1:0] frac,
                                          input sample_t dry, input longint gain);
    longint delayed;
    longint doubled;
    longint acc;
    longint mixed;
    delayed = longint'(near)
            + ((longint'(frac) * (longint'(far) - longint'(near))) >>> FRAC_BITS);
    doubled = (delayed * gain + 64'sd32768) >>> 16;
    acc     = longint'(dry) * (64'sd32768 - longint'(wet_q15))
            + doubled * longint'(wet_q15);
    mixed   = (acc + 64'sd16384) >>> 15;
    if (mixed > SAMPLE_TOP) begin
      return SMAX;
    end
    if (mixed < SAMPLE_BOTTOM) begin
      return SMIN;
    end
    return sample_t'(mixed);
  endfunction

  function automatic sample_t random_sample();
    case ($urandom_range(0, 9))
      0: return SMAX;
      1: return SMIN;
      2, 3: return sample_t'($urandom_range(0, 2000)) - sample_t'(1000);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic void add_item(input sample_t l, input sample_t r, input bit typed,
                                   input sample_t want_l, input sample_t want_r);
    plan_row_t row;
    row.is_write   = 1'b0;
    row.reg_idx    = REG_BASE_DELAY;
    row.reg_val    = '0;
    row.dry.left   = l;
    row.dry.right  = r;
    row.typed      = typed;
    row.want.left  = want_l;
    row.want.right = want_r;
    plan.push_back(row);
  endfunction

  function automatic void add_write(input logic [CFG_IDX_BITS-1:0] idx,
                                    input logic [CFG_DATA_BITS-1:0] val);
    plan_row_t row;
    row.is_write = 1'b1;
    row.reg_idx  = idx;
    row.reg_val  = val;
    row.dry      = '0;
    row.typed    = 1'b0;
    row.want     = '0;
    plan.push_back(row);
  endfunction

  // registers change only with the pipeline empty
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_pairs.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_BASE_DELAY:   base_delay_q8 = val[18:0];
      REG_MOD_DEPTH:    depth_q8      = val[15:0];
      REG_PHASE_STEP:   phase_inc     = val;
      REG_STEREO_WIDTH: width_q15     = val[16:0];
      REG_WET_MIX:      wet_q15       = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // drives one pair in bursts, then predicts the doubled output once accepted
  task automatic play_pair(input pair_t dry, input bit typed, input pair_t fixed);
    logic signed [15:0]   lfo;
    longint               dly;
    longint               pos;
    logic [ADDR_BITS-1:0] near_idx;
    logic [ADDR_BITS-1:0] far_idx;
    pair_t                want;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 16);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= dry;
    do @(posedge clk); while (!s_axis_tready);

    // write first: a zero delay reads back the pair just taken
    left_line[head]  = dry.left;
    right_line[head] = dry.right;
    lfo      = sine_q15[lfo_phase[31 -: SINE_BITS]];
    dly      = longint'(base_delay_q8) + ((longint'(lfo) * longint'(depth_q8)) >>> 15);
    pos      = longint'(head) * 256 - dly;
    near_idx = pos[POS_BITS-1:FRAC_BITS];
    far_idx  = near_idx + 1'b1;
    want.left  = mix_channel(left_line[near_idx], left_line[far_idx],
                             pos[FRAC_BITS-1:0], dry.left,
                             64'sd65536 - longint'(width_q15));
    want.right = mix_channel(right_line[near_idx], right_line[far_idx],
                             pos[FRAC_BITS-1:0], dry.right,
                             64'sd65536 + longint'(width_q15));
    pending_pairs.push_back(typed ? fixed : want);
    head      = head + 1'b1;
    lfo_phase = lfo_phase + phase_inc;
    burst_left--;
    @(negedge clk);
  endtask

  always @(negedge clk) begin : ready_pattern
    if (mode_left == 0) begin
      rx_mode   = rx_mode_t'($urandom_range(0, 3));
      mode_left = $urandom_range(40, 300);
    end
    mode_left--;
    case (rx_mode)
      RX_OPEN: m_axis_tready <= 1'b1;
      RX_COIN: m_axis_tready <= ($urandom_range(0, 1) == 1);
      RX_STALLS: begin
        if (stall_left > 0) begin
          stall_left--;
          m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 15) == 0) begin
          stall_left = $urandom_range(4, 40);
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end
      default: m_axis_tready <= ~m_axis_tready;
    endcase
  end

  always @(posedge clk) begin : check_out
    pair_t   got;
    pair_t   want;
    sample_t w;
    sample_t g;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_pairs.size() == 0) begin
        errors++;
        $display("%0t: expected no item, got left_out %0d right_out %0d",
                 $time, got.left, got.right);
      end else begin
        want = pending_pairs.pop_front();
        for (int ch = 0; ch < 2; ch++) begin
          w = ch ? want.right : want.left;
          g = ch ? got.right : got.left;
          if (g !== w) begin
            errors++;
            $display("%0t: %s expected %0d, got %0d",
                     $time, ch ? "right_out" : "left_out", w, g);
          end
        end
      end
    end
  end

  initial begin : stimulus
    plan_row_t                row;
    pair_t                    dry;
    logic [CFG_DATA_BITS-1:0] val;
    foreach (left_line[i]) begin
      left_line[i]  = '0;
      right_line[i] = '0;
    end
    head          = '0;
    lfo_phase     = '0;
    base_delay_q8 = BASE_DELAY_RST;
    depth_q8      = MOD_DEPTH_RST;
    phase_inc     = PHASE_STEP_RST;
    width_q15     = STEREO_WIDTH_RST;
    wet_q15       = WET_MIX_RST;

    // after reset the lines are empty and the LFO sits at zero: dry / 2
    add_item(SMAX, SMIN, 1'b1, HALF_MAX, HALF_MIN);
    add_item(SMIN, SMAX, 1'b1, HALF_MIN, HALF_MAX);
    add_item('0, '0, 1'b1, '0, '0);
    add_item(24'sd1, -24'sd1, 1'b1, 24'sd1, '0);
    add_item(-24'sd1, 24'sd1, 1'b1, '0, 24'sd1);
    // zero delay, frozen LFO, unity gains, fully wet: output equals input
    add_write(REG_BASE_DELAY, 32'd0);
    add_write(REG_MOD_DEPTH, 32'd0);
    add_write(REG_PHASE_STEP, 32'd0);
    add_write(REG_STEREO_WIDTH, 32'd0);
    add_write(REG_WET_MIX, 32'd32768);
    add_item(SMAX, SMIN, 1'b1, SMAX, SMIN);
    add_item(SMIN, SMAX, 1'b1, SMIN, SMAX);
    add_item(24'sh123456, 24'shABCDEF, 1'b1, 24'sh123456, 24'shABCDEF);
    // negative left gain, wet above unity, delay wrapping past the line
    add_write(REG_STEREO_WIDTH, 32'd131071);
    add_write(REG_WET_MIX, 32'd65535);
    add_write(REG_BASE_DELAY, 32'd523775);
    add_write(REG_MOD_DEPTH, 32'd65535);
    add_write(REG_PHASE_STEP, 32'hFFFF_FFFF);
    add_item(SMAX, SMAX, 1'b0, '0, '0);
    add_item(SMIN, SMIN, 1'b0, '0, '0);
    repeat (4) add_item(random_sample(), random_sample(), 1'b0, '0, '0);
    // zero base with full swing: negative delays read ahead into old samples
    add_write(REG_BASE_DELAY, 32'd0);
    add_write(REG_PHASE_STEP, 32'h4000_0000);
    add_write(REG_STEREO_WIDTH, 32'd65536);
    add_write(REG_WET_MIX, 32'd20000);
    repeat (6) add_item(random_sample(), random_sample(), 1'b0, '0, '0);
    // fully dry
    add_write(REG_WET_MIX, 32'd0);
    add_item(SMAX, SMIN, 1'b1, SMAX, SMIN);
    add_item(-24'sd1, 24'sd1, 1'b1, -24'sd1, 24'sd1);
    add_item(24'sh000100, 24'shFFFF00, 1'b1, 24'sh000100, 24'shFFFF00);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[n]) begin
      row = plan[n];
      if (row.is_write) begin
        wait_idle();
        write_reg(row.reg_idx, row.reg_val);
      end else begin
        play_pair(row.dry, row.typed, row.want);
      end
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_idle();
      // full-width values check that unused upper bits are dropped
      val = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 523775);
      write_reg(REG_BASE_DELAY, val);
      write_reg(REG_MOD_DEPTH, $urandom_range(0, 65535));
      val = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 200000);
      write_reg(REG_PHASE_STEP, val);
      val = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 65536);
      write_reg(REG_STEREO_WIDTH, val);
      val = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32768);
      write_reg(REG_WET_MIX, val);
      write_reg(REG_UNUSED, $urandom);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        dry.left  = random_sample();
        dry.right = random_sample();
        play_pair(dry, 1'b0, '0);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("stereo_modulated_delay_doubler test passed");
    end else begin
      $display("stereo_modulated_delay_doubler test failed");
    end
    $finish;
  end

endmodule
